// ===== sv/stack_vm16_execute_core_assert.svh =====
// ----------------------------------------------------------------------------
// assertion macros for the stack vm execute core
// concurrent checks that can be compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef STACK_VM16_EXECUTE_CORE_ASSERT_SVH
`define STACK_VM16_EXECUTE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define SVM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SVM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SVM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SVM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/svm16_pkg.sv =====
// ----------------------------------------------------------------------------
// svm16_pkg
// shared types and constants of the stack vm execute core
// ----------------------------------------------------------------------------
package svm16_pkg;
    localparam int REG_COUNT_DEF     = 16;
    localparam int DATA_WORDS_DEF    = 256;
    localparam int STACK_WORDS_DEF   = 256;
    localparam int PROGRAM_WORDS_DEF = 4096;
    localparam int STACK_TOP_GAP_DEF = 1;
    localparam int INSTR_WORDS       = 4;

    typedef enum logic [4:0] {
        OP_NOP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR, OP_XOR, OP_NOT,
        OP_SHL, OP_SHR, OP_MOV, OP_SET, OP_ALWAYS, OP_EQ, OP_NEQ, OP_GT, OP_LT, OP_LE,
        OP_GE, OP_NEVER, OP_PUSH, OP_POP, OP_READ, OP_WRITE, OP_CALL, OP_RET, OP_HALT,
        OP_END, OP_BAD
    } op_t;

    localparam logic [3:0] ST_OK = 4'd0, ST_HALT = 4'd1, ST_DIV0 = 4'd2, ST_MOD0 = 4'd3,
        ST_OVER = 4'd4, ST_UNDER = 4'd5, ST_BADOP = 4'd6, ST_BADIO = 4'd7, ST_END = 4'd8;
    localparam logic [15:0] IO_MEM = 16'd0, IO_DISK = 16'd1, IO_CON = 16'd2, IO_EXT = 16'd3;
    localparam logic [1:0] OK_NONE = 2'd0, OK_CHAR = 2'd1, OK_DEC = 2'd2;

    typedef struct packed {
        op_t         op;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] t;
        logic [15:0] ch;
    } instr_t;

    typedef struct packed {
        logic [15:0] next_pc;
        logic        running;
        logic [3:0]  status;
        logic [1:0]  out_kind;
        logic [15:0] out_value;
        logic        char_taken;
    } result_t;

    function automatic op_t decode_op(input logic [15:0] code);
        op_t r;
        r = OP_BAD;
        if (code <= 16'd29)
            r = op_t'(code[4:0]);
        return r;
    endfunction
endpackage

// ===== sv/svm16_front.sv =====
// ----------------------------------------------------------------------------
// svm16_front
// accepts requests, decodes opcodes and buffers them in a short queue
// ----------------------------------------------------------------------------
module svm16_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [79:0]         s_tdata,
    output logic                q_valid,
    input  logic                q_ready,
    output svm16_pkg::instr_t   q_instr
);
    import svm16_pkg::*;

    instr_t q_reg [2];
    logic   wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic push, pop;
    instr_t din;

    always_comb
    begin
        din.op = decode_op(s_tdata[15:0]);
        din.a  = s_tdata[31:16];
        din.b  = s_tdata[47:32];
        din.t  = s_tdata[63:48];
        din.ch = s_tdata[79:64];
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_instr  = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== sv/svm16_divider.sv =====
// ----------------------------------------------------------------------------
// svm16_divider
// radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module svm16_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [15:0] quotient,
    output logic [15:0] remainder
);
    logic [15:0] quo_reg, rem_reg, dvs_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic [16:0] trial;

    assign trial     = {rem_reg, quo_reg[15]} - {1'b0, dvs_reg};
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = busy_reg && (cnt_reg == 5'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 5'd16;
        end
        else if (done)
            busy_reg <= 1'b0;
        else if (busy_reg)
            cnt_reg <= cnt_reg - 5'd1;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= 16'd0;
            dvs_reg <= divisor;
        end
        else if (busy_reg && cnt_reg != 5'd0)
        begin
            if (!trial[16])
            begin
                rem_reg <= trial[15:0];
                quo_reg <= {quo_reg[14:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[14:0], quo_reg[15]};
                quo_reg <= {quo_reg[14:0], 1'b0};
            end
        end
    end
endmodule

// ===== sv/svm16_back.sv =====
// ----------------------------------------------------------------------------
// svm16_back
// executes decoded instructions against register file, memories and stack
// ----------------------------------------------------------------------------
module svm16_back #(
    parameter int REG_COUNT     = svm16_pkg::REG_COUNT_DEF,
    parameter int DATA_WORDS    = svm16_pkg::DATA_WORDS_DEF,
    parameter int STACK_WORDS   = svm16_pkg::STACK_WORDS_DEF,
    parameter int PROGRAM_WORDS = svm16_pkg::PROGRAM_WORDS_DEF,
    parameter int STACK_TOP_GAP = svm16_pkg::STACK_TOP_GAP_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_ready,
    input  svm16_pkg::instr_t   q_instr,
    input  logic                cfg_valid,
    input  logic [11:0]         cfg_data,
    output logic                res_valid,
    input  logic                res_ready,
    output svm16_pkg::result_t  res
);
    import svm16_pkg::*;

    localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int DW = $clog2(DATA_WORDS);
    localparam int SW = $clog2(STACK_WORDS);
    localparam int PW = SW + 1;
    localparam logic [PW-1:0] SP_TOP = PW'(STACK_WORDS - STACK_TOP_GAP);
    localparam logic [16:0] PROG_END = 17'(PROGRAM_WORDS);
    localparam int CLR_W = ((DATA_WORDS > STACK_WORDS) ? DW : SW) + 1;
    localparam logic [CLR_W-1:0] CLR_LAST =
        CLR_W'((DATA_WORDS > STACK_WORDS) ? DATA_WORDS - 1 : STACK_WORDS - 1);

    typedef enum logic [2:0] { S_CLEAR, S_EXEC, S_MEMRD, S_DIV, S_OUT } state_t;

    state_t      state_reg;
    logic [15:0] regs_reg [REG_COUNT];
    logic [15:0] dmem [DATA_WORDS];
    logic [15:0] smem [STACK_WORDS];
    logic [15:0] pc_reg;
    logic [PW-1:0] sp_reg;
    logic        run_reg;
    logic [CLR_W-1:0] clr_reg;
    instr_t      cur_reg;
    logic [RW-1:0] dst_reg;
    logic [15:0] rd_data_reg;
    logic        div_start;
    logic        div_done;
    logic [15:0] quo, rem;
    result_t     res_reg;

    state_t        state_next;
    logic [CLR_W-1:0] clr_next;
    logic [15:0]   pc_next;
    logic [PW-1:0] sp_next;
    logic          run_next;
    result_t       res_next;
    instr_t        cur_next;
    logic [RW-1:0] dst_next;
    logic          reg_we;
    logic [RW-1:0] reg_wa;
    logic [15:0]   reg_wd;

    logic [15:0] r1, r2, rt, np16;
    logic [16:0] np;
    logic [RW-1:0] ia, ib, it;
    logic [15:0] mul_lo;

    assign ia = q_instr.a[RW-1:0];
    assign ib = q_instr.b[RW-1:0];
    assign it = q_instr.t[RW-1:0];
    assign r1 = regs_reg[ia];
    assign r2 = regs_reg[ib];
    assign rt = regs_reg[it];
    assign np = {1'b0, pc_reg} + 17'(INSTR_WORDS);
    assign np16 = np[15:0];
    assign mul_lo = 16'(r1 * r2);

    assign q_ready   = (state_reg == S_EXEC) && !res_valid;
    assign res_valid = (state_reg == S_OUT);
    assign res       = res_reg;
    assign div_start = q_valid && q_ready && run_reg && np < PROG_END
                       && (q_instr.op == OP_DIV || q_instr.op == OP_MOD) && r2 != 16'd0;

    svm16_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(r1), .divisor(r2),
        .done(div_done), .quotient(quo), .remainder(rem)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
        begin
            if (clr_reg < CLR_W'(DATA_WORDS))
                dmem[clr_reg[DW-1:0]] <= 16'd0;
            if (clr_reg < CLR_W'(STACK_WORDS))
                smem[clr_reg[SW-1:0]] <= 16'd0;
        end
        else if (q_valid && q_ready && run_reg && np < PROG_END)
        begin
            if (q_instr.op == OP_WRITE && q_instr.a == IO_MEM)
                dmem[q_instr.b[DW-1:0]] <= rt;
            if (q_instr.op == OP_READ && q_instr.a == IO_CON && q_instr.b == 16'd1)
                dmem[q_instr.t[DW-1:0]] <= q_instr.ch;
            if (q_instr.op == OP_PUSH && sp_reg != '0)
                smem[sp_reg[SW-1:0]] <= r1;
            if (q_instr.op == OP_CALL && sp_reg != '0)
                smem[sp_reg[SW-1:0]] <= 16'(np + 17'(INSTR_WORDS));
        end
        if (q_instr.op == OP_READ)
            rd_data_reg <= dmem[q_instr.b[DW-1:0]];
        else
            rd_data_reg <= smem[SW'(sp_reg + PW'(1))];
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        pc_next    = pc_reg;
        sp_next    = sp_reg;
        run_next   = run_reg;
        res_next   = res_reg;
        cur_next   = cur_reg;
        dst_next   = dst_reg;
        reg_we     = 1'b0;
        reg_wa     = it;
        reg_wd     = 16'd0;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + CLR_W'(1);
                if (clr_reg == CLR_LAST)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (q_valid && q_ready)
                begin
                    cur_next   = q_instr;
                    dst_next   = it;
                    res_next   = '0;
                    state_next = S_OUT;
                    if (run_reg)
                    begin
                        pc_next = np16;
                        if (np >= PROG_END)
                        begin
                            run_next = 1'b0;
                            res_next.status = ST_END;
                        end
                        else
                        begin
                            unique case (q_instr.op)
                                OP_NOP, OP_NEVER: ;
                                OP_ADD:
                                begin
                                    reg_we = 1'b1;
                                    reg_wd = r1 + r2;
                                end
                                OP_SUB:
                                begin
                                    reg_we = 1'b1;
                                    reg_wd = r1 - r2;
                                end
                                OP_MUL:
                                begin
                                    reg_we = 1'b1;
                                    reg_wd = mul_lo;
                                end
                                OP_DIV, OP_MOD:
                                begin
                                    if (r2 == 16'd0)
                                    begin
                                        run_next = 1'b0;
                                        res_next.status = (q_instr.op == OP_DIV)
                                                          ? ST_DIV0 : ST_MOD0;
                                    end
                                    else
                                        state_next = S_DIV;
                                end
                                OP_AND:
                                begin
                                    reg_we = 1'b1;
                                    reg_wd = r1 & r2;
                                end
                                OP_OR:
                                begin
                                    reg_we = 1'b1;
                                    reg_wd = r1 | r2;
                                end
                                OP_XOR:
                                begin
                                    reg_we = 1'b1;
                                    reg_wd = r1 ^ r2;
                                end
                                OP_NOT:
                                begin
                                    reg_we = 1'b1;
                                    reg_wd = ~r1;
                                end
                                OP_SHL:
                                begin
                                    reg_we = 1'b1;
                                    reg_wd = r1 << r2[3:0];
                                end
                                OP_SHR:
                                begin
                                    reg_we = 1'b1;
                                    reg_wd = r1 >> r2[3:0];
                                end
                                OP_MOV:
                                begin
                                    reg_we = 1'b1;
                                    reg_wd = r1 + q_instr.b;
                                end
                                OP_SET:
                                begin
                                    reg_we = 1'b1;
                                    reg_wd = q_instr.a;
                                end
                                OP_ALWAYS:
                                    pc_next = q_instr.t;
                                OP_EQ, OP_NEQ, OP_GT, OP_LT, OP_LE, OP_GE:
                                begin
                                    if ((q_instr.op == OP_EQ && r1 == r2)
                                        || (q_instr.op == OP_NEQ && r1 != r2)
                                        || (q_instr.op == OP_GT && r1 > r2)
                                        || (q_instr.op == OP_LT && r1 < r2)
                                        || (q_instr.op == OP_LE && r1 <= r2)
                                        || (q_instr.op == OP_GE && r1 >= r2))
                                        pc_next = q_instr.t;
                                end
                                OP_PUSH, OP_CALL:
                                begin
                                    if (sp_reg == '0)
                                    begin
                                        run_next = 1'b0;
                                        res_next.status = ST_OVER;
                                    end
                                    else
                                    begin
                                        sp_next = sp_reg - PW'(1);
                                        if (q_instr.op == OP_CALL)
                                            pc_next = q_instr.t;
                                    end
                                end
                                OP_POP, OP_RET:
                                begin
                                    if (sp_reg >= SP_TOP)
                                    begin
                                        run_next = 1'b0;
                                        res_next.status = ST_UNDER;
                                    end
                                    else
                                    begin
                                        sp_next = sp_reg + PW'(1);
                                        state_next = S_MEMRD;
                                    end
                                end
                                OP_READ:
                                begin
                                    if (q_instr.a == IO_MEM)
                                        state_next = S_MEMRD;
                                    else if (q_instr.a == IO_CON)
                                    begin
                                        if (q_instr.b == 16'd0)
                                        begin
                                            reg_we = 1'b1;
                                            reg_wd = q_instr.ch;
                                            res_next.char_taken = 1'b1;
                                        end
                                        else if (q_instr.b == 16'd1)
                                            res_next.char_taken = 1'b1;
                                        else
                                        begin
                                            run_next = 1'b0;
                                            res_next.status = ST_BADIO;
                                        end
                                    end
                                end
                                OP_WRITE:
                                begin
                                    if (q_instr.a == IO_CON)
                                    begin
                                        if (q_instr.b == 16'd0)
                                        begin
                                            res_next.out_kind = OK_CHAR;
                                            res_next.out_value = rt;
                                        end
                                        else if (q_instr.b == 16'd1)
                                        begin
                                            res_next.out_kind = OK_DEC;
                                            res_next.out_value = rt;
                                        end
                                        else if (q_instr.b > 16'd4)
                                        begin
                                            run_next = 1'b0;
                                            res_next.status = ST_BADIO;
                                        end
                                    end
                                end
                                OP_HALT, OP_END:
                                begin
                                    run_next = 1'b0;
                                    res_next.status = ST_HALT;
                                end
                                default:
                                begin
                                    run_next = 1'b0;
                                    res_next.status = ST_BADOP;
                                end
                            endcase
                        end
                    end
                    res_next.next_pc = pc_next;
                    res_next.running = run_next;
                end
            end
            S_MEMRD:
            begin
                if (cur_reg.op == OP_RET)
                begin
                    pc_next = rd_data_reg;
                    res_next.next_pc = rd_data_reg;
                end
                else
                begin
                    reg_we = 1'b1;
                    reg_wa = dst_reg;
                    reg_wd = rd_data_reg;
                end
                state_next = S_OUT;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    reg_we = 1'b1;
                    reg_wa = dst_reg;
                    reg_wd = (cur_reg.op == OP_DIV) ? quo : rem;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (res_ready)
                    state_next = S_EXEC;
            end
            default: state_next = S_EXEC;
        endcase
        if (cfg_valid)
            pc_next = {4'd0, cfg_data};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            pc_reg    <= 16'd0;
            sp_reg    <= SP_TOP;
            run_reg   <= 1'b1;
            for (int i = 0; i < REG_COUNT; i++)
                regs_reg[i] <= 16'd0;
            res_reg   <= '0;
            cur_reg   <= '0;
            dst_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pc_reg    <= pc_next;
            sp_reg    <= sp_next;
            run_reg   <= run_next;
            res_reg   <= res_next;
            cur_reg   <= cur_next;
            dst_reg   <= dst_next;
            if (reg_we)
                regs_reg[reg_wa] <= reg_wd;
        end
    end
endmodule

// ===== sv/stack_vm16_execute_core.sv =====
// ----------------------------------------------------------------------------
// stack_vm16_execute_core
// 16-bit virtual machine instruction executor
// ----------------------------------------------------------------------------
// s_axis carries one instruction request: opcode, operand_a, operand_b,
// target and char_in; m_axis returns one result request per instruction with
// next_pc, running, status, out_kind, out_value and char_taken.
// cfg_valid/cfg_ready write start_address, which also reloads the pc; write
// only while idle.
// a two-entry queue parts the decode front from the execute back.
// most instructions pass from the queue into the result register; pop, ret and
// memory read first go through the registered memory read port; div and mod
// wait on the radix-2 divider, one quotient bit per cycle. one instruction
// executes at a time. after reset the data and stack memories are cleared in
// a pass over max(DATA_WORDS, STACK_WORDS) addresses, during which the queue
// takes at most two requests and nothing executes.
// a stalled m_axis_tready holds the result; the queue keeps accepting up to
// two more requests meanwhile.
// ----------------------------------------------------------------------------
`include "stack_vm16_execute_core_assert.svh"
module stack_vm16_execute_core #(
    parameter int REG_COUNT     = svm16_pkg::REG_COUNT_DEF,
    parameter int DATA_WORDS    = svm16_pkg::DATA_WORDS_DEF,
    parameter int STACK_WORDS   = svm16_pkg::STACK_WORDS_DEF,
    parameter int PROGRAM_WORDS = svm16_pkg::PROGRAM_WORDS_DEF,
    parameter int STACK_TOP_GAP = svm16_pkg::STACK_TOP_GAP_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode, operand_a, operand_b, target, char_in
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // next_pc, running, status, out_kind, out_value, char_taken, zero pad
    output logic [47:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [11:0] cfg_data
);
    import svm16_pkg::*;

    logic    q_valid, q_ready;
    instr_t  q_instr;
    result_t res;

    assign cfg_ready = 1'b1;

    svm16_front u_front (
        .clk(clk), .rst_n(rst_n), .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
        .s_tdata(s_axis_tdata), .q_valid(q_valid), .q_ready(q_ready), .q_instr(q_instr)
    );

    svm16_back #(
        .REG_COUNT(REG_COUNT), .DATA_WORDS(DATA_WORDS), .STACK_WORDS(STACK_WORDS),
        .PROGRAM_WORDS(PROGRAM_WORDS), .STACK_TOP_GAP(STACK_TOP_GAP)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_instr(q_instr),
        .cfg_valid(cfg_valid), .cfg_data(cfg_data), .res_valid(m_axis_tvalid),
        .res_ready(m_axis_tready), .res(res)
    );

    assign m_axis_tdata = {8'd0, res.char_taken, res.out_value, res.out_kind,
                           res.status, res.running, res.next_pc};

    `SVM_ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `SVM_ASSERT_IMPL(a_out_none, clk, rst_n, m_axis_tvalid && res.out_kind == OK_NONE, res.out_value == 16'd0)
    `SVM_ASSERT_IMPL(a_halt_st, clk, rst_n, m_axis_tvalid && res.status != ST_OK, !res.running)
endmodule

// ===== tb/tb_stack_vm16_execute_core.sv =====
// ----------------------------------------------------------------------------
// tb_stack_vm16_execute_core
// self-checking bench for the 16-bit virtual machine execute core: a model of
// the machine state predicts each result; directed instructions, then random
// mostly well-formed programs, with random gaps and stalls on both streams
// ----------------------------------------------------------------------------
module tb_stack_vm16_execute_core;
    import svm16_pkg::*;

    localparam int SP_RESET = STACK_WORDS_DEF - STACK_TOP_GAP_DEF;
    localparam int CYCLE_LIMIT = 600000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [11:0] cfg_data;

    stack_vm16_execute_core dut (
        .clk                       (clk),
        .rst_n                     (rst_n),
        .s_axis_tvalid             (s_axis_tvalid),
        .s_axis_tready             (s_axis_tready),
        .s_axis_tdata              (s_axis_tdata),
        .m_axis_tvalid             (m_axis_tvalid),
        .m_axis_tready             (m_axis_tready),
        .m_axis_tdata              (m_axis_tdata),
        .cfg_valid                 (cfg_valid),
        .cfg_ready                 (cfg_ready),
        .cfg_data                  (cfg_data)
    );

    // machine model
    logic [15:0] vm_regs [REG_COUNT_DEF];
    logic [15:0] vm_data [DATA_WORDS_DEF];
    logic [15:0] vm_stack [STACK_WORDS_DEF];
    logic [15:0] vm_pc;
    int          vm_sp;
    logic        vm_run;

    logic [79:0] instr_q [$];
    result_t     result_q [$];
    int          n_errors;
    int          n_sent;
    int          n_taken;
    int          n_results;
    int          n_seen;
    int          cycles;
    int          gap_max;
    int          in_gap;
    int          out_stall;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic result_t vm_execute(input logic [15:0] code, input logic [15:0] a,
                                           input logic [15:0] b, input logic [15:0] t,
                                           input logic [15:0] ch);
        result_t r;
        logic [16:0] np;
        logic [15:0] r1;
        logic [15:0] r2;
        int d;
        op_t op;
        r = '0;
        if (vm_run)
        begin
            np = {1'b0, vm_pc} + 17'(INSTR_WORDS);
            vm_pc = np[15:0];
            r1 = vm_regs[a % REG_COUNT_DEF];
            r2 = vm_regs[b % REG_COUNT_DEF];
            d = t % REG_COUNT_DEF;
            op = (code > 16'd29) ? OP_BAD : op_t'(code[4:0]);
            if (np >= 17'(PROGRAM_WORDS_DEF))
            begin
                vm_run = 1'b0;
                r.status = ST_END;
            end
            else
            begin
                case (op)
                    OP_ADD: vm_regs[d] = r1 + r2;
                    OP_SUB: vm_regs[d] = r1 - r2;
                    OP_MUL: vm_regs[d] = r1 * r2;
                    OP_DIV:
                        if (r2 == 0)
                        begin
                            vm_run = 1'b0;
                            r.status = ST_DIV0;
                        end
                        else
                            vm_regs[d] = r1 / r2;
                    OP_MOD:
                        if (r2 == 0)
                        begin
                            vm_run = 1'b0;
                            r.status = ST_MOD0;
                        end
                        else
                            vm_regs[d] = r1 % r2;
                    OP_AND: vm_regs[d] = r1 & r2;
                    OP_OR:  vm_regs[d] = r1 | r2;
                    OP_XOR: vm_regs[d] = r1 ^ r2;
                    OP_NOT: vm_regs[d] = ~r1;
                    OP_SHL: vm_regs[d] = r1 << r2[3:0];
                    OP_SHR: vm_regs[d] = r1 >> r2[3:0];
                    OP_MOV: vm_regs[d] = r1 + b;
                    OP_SET: vm_regs[d] = a;
                    OP_ALWAYS: vm_pc = t;
                    OP_EQ: if (r1 == r2) vm_pc = t;
                    OP_NEQ: if (r1 != r2) vm_pc = t;
                    OP_GT: if (r1 > r2) vm_pc = t;
                    OP_LT: if (r1 < r2) vm_pc = t;
                    OP_LE: if (r1 <= r2) vm_pc = t;
                    OP_GE: if (r1 >= r2) vm_pc = t;
                    OP_PUSH, OP_CALL:
                        if (vm_sp == 0)
                        begin
                            vm_run = 1'b0;
                            r.status = ST_OVER;
                        end
                        else
                        begin
                            vm_stack[vm_sp % STACK_WORDS_DEF] =
                                (op == OP_PUSH) ? r1 : vm_pc + 16'(INSTR_WORDS);
                            vm_sp--;
                            if (op == OP_CALL)
                                vm_pc = t;
                        end
                    OP_POP, OP_RET:
                        if (vm_sp >= SP_RESET)
                        begin
                            vm_run = 1'b0;
                            r.status = ST_UNDER;
                        end
                        else
                        begin
                            vm_sp++;
                            if (op == OP_POP)
                                vm_regs[d] = vm_stack[vm_sp % STACK_WORDS_DEF];
                            else
                                vm_pc = vm_stack[vm_sp % STACK_WORDS_DEF];
                        end
                    OP_READ:
                        if (a == IO_MEM)
                            vm_regs[d] = vm_data[b % DATA_WORDS_DEF];
                        else if (a == IO_CON)
                        begin
                            if (b == 0)
                            begin
                                vm_regs[d] = ch;
                                r.char_taken = 1'b1;
                            end
                            else if (b == 1)
                            begin
                                vm_data[t % DATA_WORDS_DEF] = ch;
                                r.char_taken = 1'b1;
                            end
                            else
                            begin
                                vm_run = 1'b0;
                                r.status = ST_BADIO;
                            end
                        end
                    OP_WRITE:
                        if (a == IO_MEM)
                            vm_data[b % DATA_WORDS_DEF] = vm_regs[d];
                        else if (a == IO_CON)
                        begin
                            if (b == 0 || b == 1)
                            begin
                                r.out_kind = (b == 0) ? OK_CHAR : OK_DEC;
                                r.out_value = vm_regs[d];
                            end
                            else if (b > 4)
                            begin
                                vm_run = 1'b0;
                                r.status = ST_BADIO;
                            end
                        end
                    OP_HALT, OP_END:
                    begin
                        vm_run = 1'b0;
                        r.status = ST_HALT;
                    end
                    OP_NOP, OP_NEVER: ;
                    default:
                    begin
                        vm_run = 1'b0;
                        r.status = ST_BADOP;
                    end
                endcase
            end
        end
        r.next_pc = vm_pc;
        r.running = vm_run;
        return r;
    endfunction

    task automatic issue(input op_t op, input logic [15:0] a, input logic [15:0] b,
                         input logic [15:0] t, input logic [15:0] ch);
        result_q.push_back(vm_execute(16'(op), a, b, t, ch));
        instr_q.push_back({ch, t, b, a, 16'(op)});
    endtask

    task automatic issue_raw(input logic [15:0] code, input logic [15:0] a,
                             input logic [15:0] b, input logic [15:0] t,
                             input logic [15:0] ch);
        result_q.push_back(vm_execute(code, a, b, t, ch));
        instr_q.push_back({ch, t, b, a, code});
    endtask

    task automatic drain();
        wait (instr_q.size() == 0 && result_q.size() == 0);
        repeat (25) @(posedge clk);
    endtask

    task automatic write_start(input logic [11:0] addr);
        drain();
        @(negedge clk);
        cfg_data <= addr;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        vm_pc = {4'd0, addr};
    endtask

    // random instruction that keeps the machine running
    task automatic issue_random();
        int sel;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] t;
        logic [15:0] ch;
        op_t op;
        a = 16'($urandom);
        b = 16'($urandom);
        t = 16'($urandom);
        ch = ($urandom_range(0, 9) == 0) ? 16'hffff : 16'($urandom);
        op = op_t'($urandom_range(0, 27));
        if (vm_pc > 16'd3800)
            op = OP_ALWAYS;
        case (op)
            OP_DIV, OP_MOD:
                if (vm_regs[b % REG_COUNT_DEF] == 0)
                    op = OP_ADD;
            OP_POP:
                if (vm_sp >= SP_RESET)
                    op = OP_PUSH;
            OP_RET:
                if (vm_sp >= SP_RESET || vm_stack[(vm_sp + 1) % STACK_WORDS_DEF] > 16'd3800)
                    op = OP_PUSH;
            default: ;
        endcase
        if ((op == OP_PUSH || op == OP_CALL) && vm_sp == 0)
            op = OP_POP;
        if (op >= OP_ALWAYS && op <= OP_GE || op == OP_CALL)
            t = 16'($urandom_range(0, 3800));
        if (op == OP_READ || op == OP_WRITE)
        begin
            sel = $urandom_range(0, 4);
            if (sel == 0 || sel == 1)
                a = IO_MEM;
            else if (sel == 2)
            begin
                a = IO_CON;
                b = 16'($urandom_range(0, (op == OP_READ) ? 1 : 4));
            end
            else if (sel == 3)
                a = ($urandom_range(0, 1) == 0) ? IO_DISK : IO_EXT;
            else if (a == IO_CON)
                a = IO_MEM;
        end
        issue(op, a, b, t, ch);
    endtask

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("mismatch %s: got %h, expected %h", what, got, want);
        n_errors++;
    endtask

    // input driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            n_sent <= 0;
            in_gap = 0;
        end
        else if (!(s_axis_tvalid && n_taken != n_sent))
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (instr_q.size() != 0)
            begin
                s_axis_tdata <= instr_q.pop_front();
                s_axis_tvalid <= 1'b1;
                n_sent <= n_sent + 1;
                in_gap = $urandom_range(0, gap_max);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // result sink
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            n_seen <= 0;
            out_stall = 0;
        end
        else
        begin
            if (n_seen != n_results)
            begin
                n_seen <= n_results;
                out_stall = $urandom_range(0, gap_max);
            end
            if (out_stall > 0)
            begin
                out_stall--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        result_t want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                n_taken <= n_taken + 1;
            if (m_axis_tvalid && m_axis_tready)
            begin
                n_results <= n_results + 1;
                if (result_q.size() == 0)
                    report("unexpected result next_pc", m_axis_tdata[15:0], 16'd0);
                else
                begin
                    want = result_q.pop_front();
                    if (m_axis_tdata[15:0] != want.next_pc)
                        report("next_pc", m_axis_tdata[15:0], want.next_pc);
                    if (m_axis_tdata[16] != want.running)
                        report("running", 16'(m_axis_tdata[16]), 16'(want.running));
                    if (m_axis_tdata[20:17] != want.status)
                        report("status", 16'(m_axis_tdata[20:17]), 16'(want.status));
                    if (m_axis_tdata[22:21] != want.out_kind)
                        report("out_kind", 16'(m_axis_tdata[22:21]), 16'(want.out_kind));
                    if (m_axis_tdata[38:23] != want.out_value)
                        report("out_value", m_axis_tdata[38:23], want.out_value);
                    if (m_axis_tdata[39] != want.char_taken)
                        report("char_taken", 16'(m_axis_tdata[39]), 16'(want.char_taken));
                end
            end
        end
    end

    initial
    begin
        int sel;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        n_errors = 0;
        n_taken = 0;
        n_results = 0;
        cycles = 0;
        gap_max = 10;
        for (int i = 0; i < REG_COUNT_DEF; i++)
            vm_regs[i] = '0;
        for (int i = 0; i < DATA_WORDS_DEF; i++)
            vm_data[i] = '0;
        for (int i = 0; i < STACK_WORDS_DEF; i++)
            vm_stack[i] = '0;
        vm_pc = '0;
        vm_sp = SP_RESET;
        vm_run = 1'b1;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        write_start(12'd0);
        // directed: extremes, wrap, each arithmetic, logic, stack and i/o operation, two branches
        issue(OP_SET, 16'hffff, 16'h0, 16'd1, 16'h0);
        issue(OP_SET, 16'h0001, 16'h0, 16'hfff2, 16'h0);
        issue(OP_ADD, 16'd1, 16'd2, 16'd3, 16'h0);
        issue(OP_SUB, 16'd0, 16'd2, 16'd4, 16'h0);
        issue(OP_MUL, 16'd1, 16'd1, 16'd5, 16'h0);
        issue(OP_DIV, 16'd1, 16'd2, 16'd6, 16'h0);
        issue(OP_MOD, 16'd1, 16'd5, 16'd7, 16'h0);
        issue(OP_SET, 16'd15, 16'h0, 16'd8, 16'h0);
        issue(OP_SHL, 16'd1, 16'd8, 16'd9, 16'h0);
        issue(OP_SHR, 16'd1, 16'd8, 16'd10, 16'h0);
        issue(OP_NOT, 16'd9, 16'd0, 16'd11, 16'h0);
        issue(OP_MOV, 16'd1, 16'hffff, 16'd12, 16'h0);
        issue(OP_AND, 16'd1, 16'd9, 16'd13, 16'h0);
        issue(OP_OR, 16'd10, 16'd9, 16'd13, 16'h0);
        issue(OP_XOR, 16'd1, 16'd11, 16'd14, 16'h0);
        issue(OP_EQ, 16'd0, 16'd0, 16'd200, 16'h0);
        issue(OP_GT, 16'd0, 16'd1, 16'd100, 16'h0);
        issue(OP_CALL, 16'd0, 16'd0, 16'd400, 16'h0);
        issue(OP_PUSH, 16'd1, 16'd0, 16'd0, 16'h0);
        issue(OP_POP, 16'd0, 16'd0, 16'd15, 16'h0);
        issue(OP_RET, 16'd0, 16'd0, 16'd0, 16'h0);
        issue(OP_WRITE, IO_MEM, 16'hffff, 16'd1, 16'h0);
        issue(OP_READ, IO_MEM, 16'h00ff, 16'd2, 16'h0);
        issue(OP_READ, IO_CON, 16'd0, 16'd3, 16'hffff);
        issue(OP_WRITE, IO_CON, 16'd1, 16'd3, 16'h0);

        for (int phase = 0; phase < 4; phase++)
        begin
            gap_max = (phase == 2) ? 0 : 10;
            case (phase)
                0: write_start(12'($urandom_range(0, 4091)));
                1: write_start(12'd4091);
                2: write_start(12'd0);
                default: write_start(12'($urandom));
            endcase
            for (int i = 0; i < 400; i++)
            begin
                if (vm_pc >= 16'd4092)
                    issue(OP_NOP, 16'h0, 16'h0, 16'h0, 16'h0);
                else
                    issue_random();
                if (i == 200)
                    wait (instr_q.size() == 0 && result_q.size() == 0);
            end
        end
        gap_max = 10;

        // one halting cause, then steps on the halted machine
        sel = $urandom_range(0, 7);
        if (sel == 7)
        begin
            write_start(12'hfff);
            issue(OP_NOP, 16'h0, 16'h0, 16'h0, 16'h0);
        end
        else if (vm_pc >= 16'd4092)
            issue(OP_NOP, 16'h0, 16'h0, 16'h0, 16'h0);
        else
        begin
            issue(OP_SET, 16'h0, 16'h0, 16'd0, 16'h0);
            case (sel)
                0: issue(OP_DIV, 16'd1, 16'd0, 16'd2, 16'h0);
                1: issue(OP_MOD, 16'd1, 16'd0, 16'd2, 16'h0);
                2: issue(OP_HALT, 16'h0, 16'h0, 16'h0, 16'h0);
                3: issue(OP_END, 16'h0, 16'h0, 16'h0, 16'h0);
                4: issue(OP_READ, IO_CON, 16'd2, 16'h0, 16'h0);
                5: issue(OP_WRITE, IO_CON, 16'hffff, 16'h0, 16'h0);
                default:
                    if (vm_sp >= SP_RESET)
                        issue(OP_POP, 16'h0, 16'h0, 16'h0, 16'h0);
                    else
                        issue_raw(16'($urandom_range(30, 65535)), 16'h0, 16'h0, 16'h0, 16'h0);
            endcase
        end
        for (int i = 0; i < 20; i++)
            issue_raw(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom));

        wait (instr_q.size() == 0 && result_q.size() == 0);
        repeat (40) @(posedge clk);
        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
